@@ rtl/lsbs_pkg.sv @@
`default_nettype none

package lsbs_pkg;

   // Scan geometry: the point counter saturates at MaxPoints - 1.
   localparam int MaxPoints  = 4096;
   localparam int PointWidth = $clog2(MaxPoints);

   // Field widths of the transactions.
   localparam int DistWidth  = 16;
   localparam int AngleWidth = 16;
   localparam int IndexWidth = 12;
   localparam int CountWidth = 13;
   localparam int BlobWidth  = 10;
   localparam int MinWidth   = 12;
   localparam int CsrWidth   = 16;

   localparam logic [CountWidth-1:0] CountMax = '1;

   // Reset values of the configuration registers.
   localparam logic [MinWidth-1:0]   KeepMinReset    = MinWidth'(4);
   localparam logic [DistWidth-1:0]  MaxGapDistReset = DistWidth'(50);
   localparam logic [AngleWidth-1:0] AngleGapReset   = AngleWidth'(100);
   localparam logic [BlobWidth-1:0]  MaxBlobsReset   = BlobWidth'(200);

   // Result queue sizing: one point causes at most three results.
   localparam int MaxResults  = 3;
   localparam int FifoDepth   = 8;
   localparam int FifoPtrW    = $clog2(FifoDepth);
   localparam int FifoCountW  = $clog2(FifoDepth + 1);
   localparam int RecIdxW     = $clog2(MaxResults + 1);

   typedef enum logic [1:0] {
      KIND_BLOB     = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_OVERFLOW = 2'd2
   } record_kind_type;

   typedef enum logic [1:0] {
      REG_KEEP_MIN     = 2'd0,
      REG_MAX_GAP_DIST = 2'd1,
      REG_ANGLE_GAP    = 2'd2,
      REG_MAX_BLOBS    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]            record_kind;
      logic [BlobWidth-1:0]  blob_number;
      logic [IndexWidth-1:0] start_index;
      logic [IndexWidth-1:0] stop_index;
      logic [CountWidth-1:0] point_count;
      logic [BlobWidth-1:0]  blob_total;
      logic                  last_record;
   } record_type;

   // Absolute difference of two distances.
   function automatic logic [DistWidth-1:0] abs_diff(input logic [DistWidth-1:0] a,
                                                     input logic [DistWidth-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Low bits of a point index as carried in a result transaction.
   function automatic logic [IndexWidth-1:0] to_index(input logic [PointWidth-1:0] v);
      logic [PointWidth+IndexWidth-1:0] wide;
      wide = {{IndexWidth{1'b0}}, v};
      return wide[IndexWidth-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/lsbs_channels.sv @@
`default_nettype none

// Point channel into the segmenter.
interface lsbs_req_if
   import lsbs_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [DistWidth-1:0]  distance;
   logic [AngleWidth-1:0] angle;
   logic                  on_table;
   logic                  last_point;

   modport source (output valid, distance, angle, on_table, last_point, input ready);
   modport sink   (input valid, distance, angle, on_table, last_point, output ready);
endinterface

// Record channel out of the segmenter.
interface lsbs_rsp_if
   import lsbs_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [1:0]            record_kind;
   logic [BlobWidth-1:0]  blob_number;
   logic [IndexWidth-1:0] start_index;
   logic [IndexWidth-1:0] stop_index;
   logic [CountWidth-1:0] point_count;
   logic [BlobWidth-1:0]  blob_total;
   logic                  last_record;

   modport source (output valid, record_kind, blob_number, start_index, stop_index,
                   point_count, blob_total, last_record, input ready);
   modport sink   (input valid, record_kind, blob_number, start_index, stop_index,
                   point_count, blob_total, last_record, output ready);
endinterface

`default_nettype wire

@@ rtl/lidar_scan_blob_segmenter_unit.sv @@
`default_nettype none

// Channel    Dir  Payload                                              Handshake
// req_chan   in   distance, angle, on_table, last_point                valid/ready
// rsp_chan   out  record_kind, blob_number, start_index, stop_index,   valid/ready
//                 point_count, blob_total, last_record
// csr_*      in   csr_index, csr_data                                  csr_write_enable
//
// A point is accepted on valid and ready; another can follow in every ready cycle.
// Its records (at most three) enter an eight-entry result queue in the same cycle
// and leave it one per ready cycle, so the sustained rate is one record per cycle.
// req_chan.ready is high while the queue has room for three more records.
// Reset is synchronous and active high; it restores the register defaults and
// clears the scan state and the queue. A stalled consumer only fills the queue.
module lidar_scan_blob_segmenter_unit
   import lsbs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   lsbs_req_if.sink                  req_chan,
   lsbs_rsp_if.source                rsp_chan,
   input  wire logic                 csr_write_enable,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CsrWidth-1:0]  csr_data
);

   // Configuration registers.
   logic [MinWidth-1:0]   keep_min_ff;
   logic [DistWidth-1:0]  max_gap_dist_ff;
   logic [AngleWidth-1:0] angle_gap_ff;
   logic [BlobWidth-1:0]  max_blobs_ff;

   // Scan state.
   logic [PointWidth-1:0] point_index_ff, point_index_in;
   logic [PointWidth-1:0] cur_start_ff, cur_start_in;
   logic [PointWidth-1:0] cur_stop_ff, cur_stop_in;
   logic [CountWidth-1:0] cur_count_ff, cur_count_in;
   logic [DistWidth-1:0]  prev_distance_ff, prev_distance_in;
   logic [AngleWidth-1:0] prev_angle_ff, prev_angle_in;
   logic [DistWidth-1:0]  first_distance_ff, first_distance_in;
   logic                  first_on_table_ff, first_on_table_in;
   logic [PointWidth-1:0] held_start_ff, held_start_in;
   logic [PointWidth-1:0] held_stop_ff, held_stop_in;
   logic [CountWidth-1:0] held_count_ff, held_count_in;
   logic [BlobWidth-1:0]  blob_counter_ff, blob_counter_in;
   logic                  overflowed_ff, overflowed_in;

   // Result queue.
   record_type              fifo_ff [FifoDepth];
   logic [FifoPtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FifoPtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FifoCountW-1:0]   fill_ff, fill_in;
   logic [FifoPtrW-1:0]     wr_addr [MaxResults];

   // Step logic.
   logic                    req_accept;
   logic                    rsp_accept;
   logic signed [AngleWidth:0] angle_step;
   logic                    jump;
   logic                    do_close;
   logic [BlobWidth-1:0]    next_blob;
   logic                    close_overflows;
   logic                    merge;
   logic [CountWidth:0]     merged_count;
   record_type              recs [MaxResults];
   logic [RecIdxW-1:0]      nrec;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_accept = rsp_chan.valid && rsp_chan.ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_min_ff     <= KeepMinReset;
         max_gap_dist_ff <= MaxGapDistReset;
         angle_gap_ff    <= AngleGapReset;
         max_blobs_ff    <= MaxBlobsReset;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_KEEP_MIN:     keep_min_ff     <= csr_data[MinWidth-1:0];
            REG_MAX_GAP_DIST: max_gap_dist_ff <= csr_data[DistWidth-1:0];
            REG_ANGLE_GAP:    angle_gap_ff    <= csr_data[AngleWidth-1:0];
            REG_MAX_BLOBS:    max_blobs_ff    <= csr_data[BlobWidth-1:0];
            default:          ;
         endcase
      end
   end

   // Break detection against the last point of the open blob.
   assign angle_step = $signed({1'b0, req_chan.angle}) - $signed({1'b0, prev_angle_ff});
   assign jump = (abs_diff(req_chan.distance, prev_distance_ff) > max_gap_dist_ff) ||
                 (angle_step > $signed({1'b0, angle_gap_ff}));

   // A blob closes on an off-table point with enough points, or on a break.
   assign do_close = !overflowed_ff &&
                     ((!req_chan.on_table && (cur_count_ff > {1'b0, keep_min_ff})) ||
                      (req_chan.on_table && (cur_count_ff != '0) && jump &&
                       (cur_count_ff >= {1'b0, keep_min_ff})));
   assign next_blob       = blob_counter_ff + BlobWidth'(1);
   assign close_overflows = (next_blob >= max_blobs_ff);

   // Next scan state and the records caused by the accepted point.
   always_comb begin
      point_index_in    = point_index_ff;
      cur_start_in      = cur_start_ff;
      cur_stop_in       = cur_stop_ff;
      cur_count_in      = cur_count_ff;
      prev_distance_in  = prev_distance_ff;
      prev_angle_in     = prev_angle_ff;
      first_distance_in = first_distance_ff;
      first_on_table_in = first_on_table_ff;
      held_start_in     = held_start_ff;
      held_stop_in      = held_stop_ff;
      held_count_in     = held_count_ff;
      blob_counter_in   = blob_counter_ff;
      overflowed_in     = overflowed_ff;
      merge             = 1'b0;
      merged_count      = '0;
      nrec              = '0;
      for (int k = 0; k < MaxResults; k++) begin
         recs[k] = '0;
      end

      if (req_accept) begin
         // The scan's first point is remembered for the wrap merge.
         if (point_index_ff == '0) begin
            first_distance_in = req_chan.distance;
            first_on_table_in = req_chan.on_table;
         end

         if (!overflowed_ff) begin
            // Close the open blob: blob 0 is held, later ones go out now.
            if (do_close) begin
               if (blob_counter_ff == '0) begin
                  held_start_in = cur_start_ff;
                  held_stop_in  = cur_stop_ff;
                  held_count_in = cur_count_ff;
               end else begin
                  recs[nrec].record_kind = KIND_BLOB;
                  recs[nrec].blob_number = blob_counter_ff;
                  recs[nrec].start_index = to_index(cur_start_ff);
                  recs[nrec].stop_index  = to_index(cur_stop_ff);
                  recs[nrec].point_count = cur_count_ff;
                  nrec = nrec + RecIdxW'(1);
               end
               blob_counter_in = next_blob;
               cur_count_in    = '0;
               if (close_overflows) begin
                  overflowed_in = 1'b1;
               end
            end

            // Grow, restart or drop the open blob.
            if (!req_chan.on_table) begin
               cur_count_in = '0;
            end else if (cur_count_ff == '0) begin
               cur_start_in     = point_index_ff;
               cur_stop_in      = point_index_ff;
               cur_count_in     = CountWidth'(1);
               prev_distance_in = req_chan.distance;
               prev_angle_in    = req_chan.angle;
            end else begin
               if (jump) begin
                  if (!(do_close && close_overflows)) begin
                     cur_start_in = point_index_ff;
                     cur_stop_in  = point_index_ff;
                     cur_count_in = CountWidth'(1);
                  end
               end else begin
                  cur_stop_in = point_index_ff;
                  if (cur_count_ff != CountMax) begin
                     cur_count_in = cur_count_ff + CountWidth'(1);
                  end
               end
               prev_distance_in = req_chan.distance;
               prev_angle_in    = req_chan.angle;
            end
         end

         if (req_chan.last_point) begin
            // Scan end: overflow record, or blob 0 (with wrap merge) and done.
            if (overflowed_in) begin
               recs[nrec].record_kind = KIND_OVERFLOW;
               nrec = nrec + RecIdxW'(1);
            end else begin
               if (blob_counter_in != '0) begin
                  merge = first_on_table_in && req_chan.on_table &&
                          (abs_diff(first_distance_in, req_chan.distance) < max_gap_dist_ff);
                  merged_count = {1'b0, held_count_in} + {1'b0, cur_count_in};
                  if (merge) begin
                     held_start_in = cur_start_in;
                     held_count_in = merged_count[CountWidth] ? CountMax :
                                     merged_count[CountWidth-1:0];
                  end
                  recs[nrec].record_kind = KIND_BLOB;
                  recs[nrec].start_index = to_index(held_start_in);
                  recs[nrec].stop_index  = to_index(held_stop_in);
                  recs[nrec].point_count = held_count_in;
                  nrec = nrec + RecIdxW'(1);
               end
               recs[nrec].record_kind = KIND_DONE;
               recs[nrec].blob_total  = blob_counter_in;
               nrec = nrec + RecIdxW'(1);
            end
            point_index_in    = '0;
            cur_start_in      = '0;
            cur_stop_in       = '0;
            cur_count_in      = '0;
            prev_distance_in  = '0;
            prev_angle_in     = '0;
            first_distance_in = '0;
            first_on_table_in = 1'b0;
            held_start_in     = '0;
            held_stop_in      = '0;
            held_count_in     = '0;
            blob_counter_in   = '0;
            overflowed_in     = 1'b0;
         end else if (point_index_ff != PointWidth'(MaxPoints - 1)) begin
            point_index_in = point_index_ff + PointWidth'(1);
         end

         // Mark the final record of this point.
         if (nrec != '0) begin
            recs[nrec - RecIdxW'(1)].last_record = 1'b1;
         end
      end
   end

   // Scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         point_index_ff    <= '0;
         cur_start_ff      <= '0;
         cur_stop_ff       <= '0;
         cur_count_ff      <= '0;
         prev_distance_ff  <= '0;
         prev_angle_ff     <= '0;
         first_distance_ff <= '0;
         first_on_table_ff <= 1'b0;
         held_start_ff     <= '0;
         held_stop_ff      <= '0;
         held_count_ff     <= '0;
         blob_counter_ff   <= '0;
         overflowed_ff     <= 1'b0;
      end else begin
         point_index_ff    <= point_index_in;
         cur_start_ff      <= cur_start_in;
         cur_stop_ff       <= cur_stop_in;
         cur_count_ff      <= cur_count_in;
         prev_distance_ff  <= prev_distance_in;
         prev_angle_ff     <= prev_angle_in;
         first_distance_ff <= first_distance_in;
         first_on_table_ff <= first_on_table_in;
         held_start_ff     <= held_start_in;
         held_stop_ff      <= held_stop_in;
         held_count_ff     <= held_count_in;
         blob_counter_ff   <= blob_counter_in;
         overflowed_ff     <= overflowed_in;
      end
   end

   // Queue pointers and fill level.
   always_comb begin
      for (int k = 0; k < MaxResults; k++) begin
         wr_addr[k] = wr_ptr_ff + FifoPtrW'(k);
      end
      wr_ptr_in = wr_ptr_ff + FifoPtrW'(nrec);
      rd_ptr_in = rsp_accept ? (rd_ptr_ff + FifoPtrW'(1)) : rd_ptr_ff;
      fill_in   = fill_ff + FifoCountW'(nrec) - FifoCountW'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage: up to three records written per transaction.
   always_ff @(posedge clock) begin
      for (int k = 0; k < MaxResults; k++) begin
         if (RecIdxW'(k) < nrec) begin
            fifo_ff[wr_addr[k]] <= recs[k];
         end
      end
   end

   // Channel outputs.
   assign req_chan.ready       = (fill_ff <= FifoCountW'(FifoDepth - MaxResults));
   assign rsp_chan.valid       = (fill_ff != '0);
   assign rsp_chan.record_kind = fifo_ff[rd_ptr_ff].record_kind;
   assign rsp_chan.blob_number = fifo_ff[rd_ptr_ff].blob_number;
   assign rsp_chan.start_index = fifo_ff[rd_ptr_ff].start_index;
   assign rsp_chan.stop_index  = fifo_ff[rd_ptr_ff].stop_index;
   assign rsp_chan.point_count = fifo_ff[rd_ptr_ff].point_count;
   assign rsp_chan.blob_total  = fifo_ff[rd_ptr_ff].blob_total;
   assign rsp_chan.last_record = fifo_ff[rd_ptr_ff].last_record;

endmodule

`default_nettype wire
